// ----- rtl/core/mflt_pkg.sv -----
`default_nettype none

package mflt_pkg;

    // frame limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DRN_W      = COL_W + 1;
    localparam int WIN_N      = 9;

    // configuration reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // result queue at the output
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_t;

    typedef logic [PIX_W-1:0] pix_t;

    // 3x3 window, row-major: index = row*3 + column
    typedef pix_t [WIN_N-1:0] win_t;

    // classified work handed from front to back
    typedef struct packed {
        logic             is_drain;
        logic             first;
        logic             emit1;
        logic             emit2;
        logic             top_mid;
        logic             last;
        logic [COL_W-1:0] addr0;
        logic [COL_W-1:0] addr1;
        logic [COL_W-1:0] addr2;
        pix_t             px;
    } cmd_t;

    // one output queue entry holds the results of one item
    typedef struct packed {
        logic two;
        logic fe0;
        pix_t f0;
        pix_t f1;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/median_filter_3x3_replicated_border.sv -----
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ----------------------------------
// input     in         push / full            req_type, pixel
// result    out        empty / pop            filtered, frame_end, run_end
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input transaction per clock, pixel and drain items alike; full rises only
// when the four-entry command queue backs up. Results leave one per clock while
// popped and not empty, so a row-ending pixel past row 0 (two results) needs two
// pops. A result passes command queue, line-store read, window stage, two median
// stages. The back issues only while the eight-entry result queue can hold all
// in flight. Reset is asynchronous: counters, queues and window clear, size goes
// to 640x480; the line stores are not cleared and need no clearing pass.
`default_nettype none

module median_filter_3x3_replicated_border
    import mflt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             req_type,
    input  logic [PIX_W-1:0] pixel,
    output logic             empty,
    input  logic             pop,
    output logic [PIX_W-1:0] filtered,
    output logic             frame_end,
    output logic             run_end,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    logic                  cmd_push;
    cmd_t                  cmd_in;
    logic                  cmd_valid;
    logic                  cmd_pop;
    cmd_t                  cmd_out;
    logic [OUTQ_CNT_W-1:0] out_cnt;
    logic                  out_push;
    res_t                  out_entry;

    mflt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .pixel     (pixel),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    mflt_cmd_fifo u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .full     (full),
        .rd_en    (cmd_pop),
        .rd_valid (cmd_valid),
        .rd_data  (cmd_out)
    );

    mflt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_cnt   (out_cnt),
        .out_push  (out_push),
        .out_entry (out_entry)
    );

    mflt_out_fifo u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (out_push),
        .wr_data   (out_entry),
        .cnt       (out_cnt),
        .empty     (empty),
        .pop       (pop),
        .filtered  (filtered),
        .frame_end (frame_end),
        .run_end   (run_end)
    );

`ifndef NO_ASSERTIONS
    // issue credit keeps the result queue from overflowing
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_cnt < OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue written while full");

    // work enters the command queue only on an accepted transaction
    a_cmd_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (push && !full))
        else $error("command pushed without an accepted transaction");

    // the last result of a frame always ends its item's run
    a_frame_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> run_end)
        else $error("frame_end without run_end");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mflt_front.sv -----
`default_nettype none

module mflt_front
    import mflt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic             push,
    input  logic             full,
    input  logic             req_type,
    input  pix_t             pixel,
    output logic             cmd_push,
    output cmd_t             cmd
);

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(2))
            r = DIM_W'(2);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [DRN_W-1:0] drain_reg, drain_next;

    logic [DIM_W-1:0] w_m1_full;
    logic [DIM_W-1:0] h_m1_full;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [DRN_W-1:0] drain_m1;
    logic [COL_W-1:0] dc;
    logic [COL_W-1:0] dc_m1;
    logic [COL_W-1:0] cl, cm, cr;
    logic             d_last;
    logic             draining;
    logic             is_drain_item;
    logic             accept;
    logic             row_end;
    logic             row_nz;

    assign cfg_ready = 1'b1;

    // effective frame size, saturated to the supported range
    assign w_m1_full = eff_dim(width_reg, MAX_W_DIM) - DIM_W'(1);
    assign h_m1_full = eff_dim(height_reg, MAX_H_DIM) - DIM_W'(1);
    assign wm1       = w_m1_full[COL_W-1:0];
    assign hm1       = h_m1_full[ROW_W-1:0];

    assign accept        = push && !full;
    assign is_drain_item = (req_type == REQ_DRAIN);
    assign draining      = (drain_reg != '0);

    // drain column and its clamped neighbors
    assign drain_m1 = drain_reg - DRN_W'(1);
    assign dc       = drain_m1[COL_W-1:0];
    assign dc_m1    = dc - COL_W'(1);
    assign d_last   = (dc >= wm1);
    assign cm       = d_last ? wm1 : dc;
    assign cr       = d_last ? wm1 : dc + COL_W'(1);
    assign cl       = (dc == '0) ? '0 : ((dc > wm1) ? wm1 : dc_m1);

    // pixel position flags
    assign row_end = (col_reg >= wm1);
    assign row_nz  = (row_reg != '0);

    // command build
    always_comb
    begin
        cmd          = '0;
        cmd.px       = pixel;
        cmd.is_drain = is_drain_item;
        if (is_drain_item)
        begin
            cmd.last  = d_last;
            cmd.addr0 = cl;
            cmd.addr1 = cm;
            cmd.addr2 = cr;
        end
        else
        begin
            cmd.first   = (col_reg == '0);
            cmd.emit1   = (col_reg != '0) && row_nz;
            cmd.emit2   = row_end && row_nz;
            cmd.top_mid = (row_reg == ROW_W'(1));
            cmd.addr0   = col_reg;
            cmd.addr1   = col_reg;
            cmd.addr2   = col_reg;
        end
    end

    // ignored items are taken but produce no work
    assign cmd_push = accept && (is_drain_item ? draining : !draining);

    // position counters
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (accept)
        begin
            if (is_drain_item)
            begin
                if (draining)
                    drain_next = d_last ? '0 : drain_reg + DRN_W'(1);
            end
            else if (!draining)
            begin
                if (row_end)
                begin
                    col_next = '0;
                    if (row_reg >= hm1)
                    begin
                        row_next   = '0;
                        drain_next = DRN_W'(1);
                    end
                    else
                        row_next = row_reg + ROW_W'(1);
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
        end
    end

    // configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mflt_cmd_fifo.sv -----
`default_nettype none

module mflt_cmd_fifo
    import mflt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_data
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + CMDQ_PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + CMDQ_PTR_W'(1);
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CMDQ_CNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - CMDQ_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ----- rtl/core/mflt_median9.sv -----
`default_nettype none

module mflt_median9
    import mflt_pkg::*;
(
    input  logic clk,
    input  win_t win,
    output pix_t med
);

    typedef struct packed {
        pix_t lo;
        pix_t mid;
        pix_t hi;
    } trio_t;

    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t  x1, y1, x2;
        trio_t t;
        x1    = (a < b) ? a : b;
        y1    = (a < b) ? b : a;
        x2    = (y1 < c) ? y1 : c;
        t.hi  = (y1 < c) ? c : y1;
        t.lo  = (x1 < x2) ? x1 : x2;
        t.mid = (x1 < x2) ? x2 : x1;
        return t;
    endfunction

    trio_t row_reg [3];
    pix_t  lo_max_reg;
    pix_t  mid_med_reg;
    pix_t  hi_min_reg;
    trio_t lo_t, mid_t, hi_t, fin_t;

    // stage 1: sort each window row
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            row_reg[r] <= sort3(win[r*3], win[r*3+1], win[r*3+2]);
    end

    // stage 2: max of minima, median of medians, min of maxima
    assign lo_t  = sort3(row_reg[0].lo, row_reg[1].lo, row_reg[2].lo);
    assign mid_t = sort3(row_reg[0].mid, row_reg[1].mid, row_reg[2].mid);
    assign hi_t  = sort3(row_reg[0].hi, row_reg[1].hi, row_reg[2].hi);

    always_ff @(posedge clk)
    begin
        lo_max_reg  <= lo_t.hi;
        mid_med_reg <= mid_t.mid;
        hi_min_reg  <= hi_t.lo;
    end

    // final median of the three candidates
    assign fin_t = sort3(lo_max_reg, mid_med_reg, hi_min_reg);
    assign med   = fin_t.mid;

endmodule

`default_nettype wire

// ----- rtl/core/mflt_back.sv -----
`default_nettype none

module mflt_back
    import mflt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    input  logic [OUTQ_CNT_W-1:0] out_cnt,
    output logic                  out_push,
    output res_t                  out_entry
);

    localparam int USE_W = OUTQ_CNT_W + 1;

    typedef struct packed {
        logic has;
        logic two;
        logic fe;
    } flag_t;

    // line stores, duplicated for a third read port
    pix_t prev_a_mem [MAX_WIDTH];
    pix_t prev_b_mem [MAX_WIDTH];
    pix_t cur_a_mem  [MAX_WIDTH];
    pix_t cur_b_mem  [MAX_WIDTH];

    pix_t prev_rd0_reg, prev_rd1_reg, prev_rd2_reg;
    pix_t cur_rd0_reg, cur_rd1_reg, cur_rd2_reg;
    logic [2:0] hit_reg;
    pix_t fwd_prev_reg, fwd_cur_reg;

    logic sb_valid_reg;
    cmd_t sb_cmd_reg;
    win_t win_reg;

    logic  ln_valid_reg, m1_valid_reg, m2_valid_reg;
    flag_t ln_flag_reg, m1_flag_reg, m2_flag_reg;
    win_t  ln_win0_reg, ln_win1_reg;

    logic [USE_W-1:0] used;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    pix_t             prev_wd, cur_wd;
    pix_t             p0, p1, p2, c0, c1, c2;
    pix_t             ncol [3];
    win_t             w1, w2, dwin, win_next;
    flag_t            sb_flag;
    pix_t             med0, med1;

    // issue only when the result queue can hold everything in flight
    assign used    = USE_W'(out_cnt) + USE_W'(sb_valid_reg) + USE_W'(ln_valid_reg)
                   + USE_W'(m1_valid_reg) + USE_W'(m2_valid_reg);
    assign cmd_pop = cmd_valid && (used < USE_W'(OUTQ_DEPTH));

    // line store write from the window stage
    assign wr_en   = sb_valid_reg && !sb_cmd_reg.is_drain;
    assign wr_addr = sb_cmd_reg.addr0;
    assign prev_wd = c0;
    assign cur_wd  = sb_cmd_reg.px;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            prev_a_mem[wr_addr] <= prev_wd;
        prev_rd0_reg <= prev_a_mem[cmd.addr0];
        prev_rd1_reg <= prev_a_mem[cmd.addr1];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            prev_b_mem[wr_addr] <= prev_wd;
        prev_rd2_reg <= prev_b_mem[cmd.addr2];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cur_a_mem[wr_addr] <= cur_wd;
        cur_rd0_reg <= cur_a_mem[cmd.addr0];
        cur_rd1_reg <= cur_a_mem[cmd.addr1];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cur_b_mem[wr_addr] <= cur_wd;
        cur_rd2_reg <= cur_b_mem[cmd.addr2];
    end

    // forward a write that lands in the same cycle as a read
    always_ff @(posedge clk)
    begin
        hit_reg[0]   <= wr_en && (cmd.addr0 == wr_addr);
        hit_reg[1]   <= wr_en && (cmd.addr1 == wr_addr);
        hit_reg[2]   <= wr_en && (cmd.addr2 == wr_addr);
        fwd_prev_reg <= prev_wd;
        fwd_cur_reg  <= cur_wd;
    end

    assign p0 = hit_reg[0] ? fwd_prev_reg : prev_rd0_reg;
    assign p1 = hit_reg[1] ? fwd_prev_reg : prev_rd1_reg;
    assign p2 = hit_reg[2] ? fwd_prev_reg : prev_rd2_reg;
    assign c0 = hit_reg[0] ? fwd_cur_reg : cur_rd0_reg;
    assign c1 = hit_reg[1] ? fwd_cur_reg : cur_rd1_reg;
    assign c2 = hit_reg[2] ? fwd_cur_reg : cur_rd2_reg;

    // window stage: new column, shifted windows, drain window
    always_comb
    begin
        ncol[0] = sb_cmd_reg.top_mid ? c0 : p0;
        ncol[1] = c0;
        ncol[2] = sb_cmd_reg.px;
        for (int r = 0; r < 3; r++)
        begin
            if (sb_cmd_reg.first)
            begin
                w1[r*3]   = ncol[r];
                w1[r*3+1] = ncol[r];
                w1[r*3+2] = ncol[r];
            end
            else
            begin
                w1[r*3]   = win_reg[r*3+1];
                w1[r*3+1] = win_reg[r*3+2];
                w1[r*3+2] = ncol[r];
            end
            w2[r*3]   = w1[r*3+1];
            w2[r*3+1] = w1[r*3+2];
            w2[r*3+2] = ncol[r];
        end
        dwin[0] = p0;
        dwin[1] = p1;
        dwin[2] = p2;
        for (int r = 1; r < 3; r++)
        begin
            dwin[r*3]   = c0;
            dwin[r*3+1] = c1;
            dwin[r*3+2] = c2;
        end
        win_next = sb_cmd_reg.emit2 ? w2 : w1;
    end

    assign sb_flag.has = sb_cmd_reg.is_drain || sb_cmd_reg.emit1;
    assign sb_flag.two = !sb_cmd_reg.is_drain && sb_cmd_reg.emit2;
    assign sb_flag.fe  = sb_cmd_reg.is_drain && sb_cmd_reg.last;

    // pipeline valid bits and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg <= 1'b0;
            ln_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            sb_valid_reg <= cmd_pop;
            ln_valid_reg <= sb_valid_reg;
            m1_valid_reg <= ln_valid_reg;
            m2_valid_reg <= m1_valid_reg;
            if (wr_en)
                win_reg <= win_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        sb_cmd_reg  <= cmd;
        ln_flag_reg <= sb_flag;
        ln_win0_reg <= sb_cmd_reg.is_drain ? dwin : w1;
        ln_win1_reg <= w2;
        m1_flag_reg <= ln_flag_reg;
        m2_flag_reg <= m1_flag_reg;
    end

    mflt_median9 u_med0 (
        .clk (clk),
        .win (ln_win0_reg),
        .med (med0)
    );

    mflt_median9 u_med1 (
        .clk (clk),
        .win (ln_win1_reg),
        .med (med1)
    );

    // results of one item go to the queue as one entry
    assign out_push      = m2_valid_reg && m2_flag_reg.has;
    assign out_entry.two = m2_flag_reg.two;
    assign out_entry.fe0 = m2_flag_reg.fe;
    assign out_entry.f0  = med0;
    assign out_entry.f1  = med1;

endmodule

`default_nettype wire

// ----- rtl/core/mflt_out_fifo.sv -----
`default_nettype none

module mflt_out_fifo
    import mflt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  res_t                  wr_data,
    output logic [OUTQ_CNT_W-1:0] cnt,
    output logic                  empty,
    input  logic                  pop,
    output pix_t                  filtered,
    output logic                  frame_end,
    output logic                  run_end
);

    res_t                  slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  sub_reg, sub_next;
    res_t                  head;
    logic                  take;
    logic                  retire;

    assign cnt   = cnt_reg;
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // present the first or second result of the head entry
    assign filtered  = sub_reg ? head.f1 : head.f0;
    assign frame_end = !sub_reg && head.fe0;
    assign run_end   = sub_reg || !head.two;

    assign take   = pop && !empty;
    assign retire = take && (sub_reg || !head.two);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        sub_next    = sub_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + OUTQ_PTR_W'(1);
        if (retire)
            rd_ptr_next = (rd_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + OUTQ_PTR_W'(1);
        if (take)
            sub_next = !retire;
        if (wr_en && !retire)
            cnt_next = cnt_reg + OUTQ_CNT_W'(1);
        else if (retire && !wr_en)
            cnt_next = cnt_reg - OUTQ_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire
